### rtl/core/dsp_pkg.sv
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types and codes for the DDS step pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dsp_pkg;

  localparam int unsigned FIELD_W = 32;

  // item kinds
  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_ENABLE   = 3'd1,
    MODE_DIR      = 3'd2,
    MODE_RUN      = 3'd3,
    MODE_STOP     = 3'd4,
    MODE_MOVE_TO  = 3'd5,
    MODE_MOVE_BY  = 3'd6,
    MODE_SET_POS  = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    RS_STOPPED    = 2'd0,
    RS_CONTINUOUS = 2'd1,
    RS_TARGET     = 2'd2
  } run_state_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [FIELD_W-1:0] value;
    logic        [FIELD_W-1:0] increment;
  } in_item_t;

  typedef struct packed {
    logic                      step_pulse;
    logic                      step_positive;
    logic signed [FIELD_W-1:0] position_now;
    logic                      move_done;
    logic                      axis_enabled;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/dsp_if.sv
// ----------------------------------------------------------------------------
// dsp_in_if / dsp_out_if
// Valid/ready channels for commands and ticks in, step results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [2:0]                            mode;
  logic signed [dsp_pkg::FIELD_W-1:0]    value;
  logic        [dsp_pkg::FIELD_W-1:0]    increment;

  modport source (output valid, mode, value, increment, input ready);
  modport sink   (input valid, mode, value, increment, output ready);
endinterface

interface dsp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  step_pulse;
  logic                                  step_positive;
  logic signed [dsp_pkg::FIELD_W-1:0]    position_now;
  logic                                  move_done;
  logic                                  axis_enabled;

  modport source (output valid, step_pulse, step_positive, position_now, move_done,
                  axis_enabled, input ready);
  modport sink   (input valid, step_pulse, step_positive, position_now, move_done,
                  axis_enabled, output ready);
endinterface

`default_nettype wire

### rtl/core/dsp_in_reg.sv
// ----------------------------------------------------------------------------
// dsp_in_reg
// Input register: holds one accepted word until the axis stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_in_reg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  dsp_in_if.sink            in_ch,
  output dsp_pkg::in_item_t item,
  output logic              item_valid,
  input  wire logic         item_take
);

  logic              valid_r, valid_nxt;
  dsp_pkg::in_item_t item_r;
  logic              in_fire;

  assign in_ch.ready = !valid_r || item_take;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign valid_nxt   = in_fire || (valid_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.mode      <= dsp_pkg::mode_t'(in_ch.mode);
      item_r.value     <= in_ch.value;
      item_r.increment <= in_ch.increment;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

`default_nettype wire

### rtl/core/dsp_axis.sv
// ----------------------------------------------------------------------------
// dsp_axis
// Axis state, phase accumulator and command decode, with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_axis #(
  parameter int unsigned ACC_WIDTH = 32,
  parameter int unsigned POS_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  dsp_pkg::in_item_t item,
  input  wire logic         item_valid,
  output logic              item_take,
  dsp_out_if.source         out_ch
);

  logic [ACC_WIDTH-1:0]  acc_r, acc_nxt;
  logic [ACC_WIDTH-1:0]  rate_r, rate_nxt;
  logic [POS_WIDTH-1:0]  pos_r, pos_nxt;
  logic [POS_WIDTH-1:0]  tgt_r, tgt_nxt;
  logic                  dir_r, dir_nxt;
  logic                  en_r, en_nxt;
  dsp_pkg::run_state_t   rs_r, rs_nxt;
  logic                  stepped;

  logic                  out_valid_r, out_valid_nxt;
  dsp_pkg::out_item_t    out_r, out_nxt;
  logic                  fire;

  logic [ACC_WIDTH-1:0]  inc;
  logic [POS_WIDTH-1:0]  val;
  logic [POS_WIDTH-1:0]  move_tgt;
  logic [ACC_WIDTH:0]    acc_sum;
  logic [POS_WIDTH-1:0]  pos_stepped;

  assign fire          = item_valid && (!out_valid_r || out_ch.ready);
  assign item_take     = fire;
  assign out_valid_nxt = fire || (out_valid_r && !out_ch.ready);

  // value sign-extends or truncates; increment zero-extends or truncates
  assign val         = POS_WIDTH'(item.value);
  assign inc         = ACC_WIDTH'(item.increment);
  assign move_tgt    = (item.mode == dsp_pkg::MODE_MOVE_BY) ? pos_r + val : val;
  assign acc_sum     = {1'b0, acc_r} + {1'b0, rate_r};
  assign pos_stepped = dir_r ? pos_r + POS_WIDTH'(1) : pos_r - POS_WIDTH'(1);

  always_comb begin
    acc_nxt  = acc_r;
    rate_nxt = rate_r;
    pos_nxt  = pos_r;
    tgt_nxt  = tgt_r;
    dir_nxt  = dir_r;
    en_nxt   = en_r;
    rs_nxt   = rs_r;
    stepped  = 1'b0;

    unique case (item.mode)
      dsp_pkg::MODE_TICK: begin
        if (en_r && rs_r != dsp_pkg::RS_STOPPED && rate_r != '0) begin
          acc_nxt = acc_sum[ACC_WIDTH-1:0];
          if (acc_sum[ACC_WIDTH]) begin
            stepped = 1'b1;
            pos_nxt = pos_stepped;
            // target reached or overshot in the direction of travel
            if (rs_r == dsp_pkg::RS_TARGET &&
                ((dir_r && $signed(pos_stepped) >= $signed(tgt_r)) ||
                 (!dir_r && $signed(pos_stepped) <= $signed(tgt_r)))) begin
              rate_nxt = '0;
              rs_nxt   = dsp_pkg::RS_STOPPED;
            end
          end
        end
      end
      dsp_pkg::MODE_ENABLE: begin
        en_nxt = item.value[0];
        if (!item.value[0]) begin
          rs_nxt = dsp_pkg::RS_STOPPED;
        end
      end
      dsp_pkg::MODE_DIR: begin
        dir_nxt = item.value[0];
      end
      dsp_pkg::MODE_RUN: begin
        rate_nxt = inc;
        rs_nxt   = (inc == '0) ? dsp_pkg::RS_STOPPED : dsp_pkg::RS_CONTINUOUS;
      end
      dsp_pkg::MODE_STOP: begin
        rate_nxt = '0;
        rs_nxt   = dsp_pkg::RS_STOPPED;
      end
      dsp_pkg::MODE_MOVE_TO, dsp_pkg::MODE_MOVE_BY: begin
        if (move_tgt == pos_r || inc == '0) begin
          rate_nxt = '0;
          rs_nxt   = dsp_pkg::RS_STOPPED;
        end else begin
          dir_nxt  = $signed(move_tgt) > $signed(pos_r);
          tgt_nxt  = move_tgt;
          rate_nxt = inc;
          rs_nxt   = dsp_pkg::RS_TARGET;
        end
      end
      dsp_pkg::MODE_SET_POS: begin
        pos_nxt = val;
        tgt_nxt = val;
      end
      default: begin
      end
    endcase

    out_nxt.step_pulse    = stepped;
    out_nxt.step_positive = dir_nxt;
    out_nxt.position_now  = dsp_pkg::FIELD_W'(pos_nxt);
    out_nxt.move_done     = (rs_nxt == dsp_pkg::RS_STOPPED);
    out_nxt.axis_enabled  = en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      rate_r      <= '0;
      pos_r       <= '0;
      tgt_r       <= '0;
      dir_r       <= 1'b1;
      en_r        <= 1'b0;
      rs_r        <= dsp_pkg::RS_STOPPED;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        acc_r  <= acc_nxt;
        rate_r <= rate_nxt;
        pos_r  <= pos_nxt;
        tgt_r  <= tgt_nxt;
        dir_r  <= dir_nxt;
        en_r   <= en_nxt;
        rs_r   <= rs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.step_pulse    = out_r.step_pulse;
  assign out_ch.step_positive = out_r.step_positive;
  assign out_ch.position_now  = out_r.position_now;
  assign out_ch.move_done     = out_r.move_done;
  assign out_ch.axis_enabled  = out_r.axis_enabled;

endmodule

`default_nettype wire

### rtl/core/dds_step_pulse_generator.sv
// ----------------------------------------------------------------------------
// dds_step_pulse_generator
// Phase-accumulator stepper step generator: ticks and axis commands in,
// one status word with the step pulse out per input word.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------------
//  in_ch   | in  | valid/ready | mode, value, increment
//  out_ch  | out | valid/ready | step_pulse, step_positive, position_now,
//          |     |             | move_done, axis_enabled
//
//  The result is registered: input register, then the accumulator add /
//  position update / target compare into the result register.
//  One word per cycle sustained while out_ch is ready; the axis state updates as
//  each word moves into the result register.
//  Synchronous active-low reset: axis disabled, stopped, direction positive.
//  A stalled out_ch holds the result and fills the input register, then in_ch
//  deasserts ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_step_pulse_generator #(
  parameter int unsigned ACC_WIDTH = 32,
  parameter int unsigned POS_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dsp_in_if.sink    in_ch,
  dsp_out_if.source out_ch
);

  dsp_pkg::in_item_t item;
  logic              item_valid;
  logic              item_take;

  dsp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  dsp_axis #(
    .ACC_WIDTH (ACC_WIDTH),
    .POS_WIDTH (POS_WIDTH)
  ) u_axis (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb - DDS step pulse generator bench
// Drives ticks and axis commands through the valid/ready input channel and
// checks every status word against a cycle-free model of the axis, with
// random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------

class step_scoreboard;
  logic [31:0]         acc;
  logic [31:0]         rate;
  logic [31:0]         position;
  logic [31:0]         target;
  logic                dir_pos;
  logic                enabled;
  dsp_pkg::run_state_t state;
  dsp_pkg::out_item_t  pending[$];
  int                  errors;
  int                  checked;
  int                  steps;
  int                  arrivals;

  function new();
    acc      = '0;
    rate     = '0;
    position = '0;
    target   = '0;
    dir_pos  = 1'b1;
    enabled  = 1'b0;
    state    = dsp_pkg::RS_STOPPED;
  endfunction

  function void halt();
    rate  = '0;
    state = dsp_pkg::RS_STOPPED;
  endfunction

  function void aim(logic [31:0] tgt, logic [31:0] inc);
    if (tgt == position || inc == 0) begin
      halt();
    end else begin
      dir_pos = $signed(tgt) > $signed(position);
      target  = tgt;
      rate    = inc;
      state   = dsp_pkg::RS_TARGET;
    end
  endfunction

  // axis update for one word, returns the status word it produces
  function dsp_pkg::out_item_t advance(dsp_pkg::in_item_t w);
    dsp_pkg::out_item_t r;
    logic [32:0]        sum;
    logic               pulse;
    logic               reached;
    pulse = 1'b0;
    case (w.mode)
      dsp_pkg::MODE_TICK: begin
        if (enabled && state != dsp_pkg::RS_STOPPED && rate != 0) begin
          sum = {1'b0, acc} + {1'b0, rate};
          acc = sum[31:0];
          if (sum[32]) begin
            pulse = 1'b1;
            steps++;
            position = dir_pos ? position + 32'd1 : position - 32'd1;
            reached = dir_pos ? ($signed(position) >= $signed(target))
                              : ($signed(position) <= $signed(target));
            if (state == dsp_pkg::RS_TARGET && reached) begin
              halt();
              arrivals++;
            end
          end
        end
      end
      dsp_pkg::MODE_ENABLE: begin
        enabled = w.value[0];
        if (!enabled) state = dsp_pkg::RS_STOPPED;
      end
      dsp_pkg::MODE_DIR: dir_pos = w.value[0];
      dsp_pkg::MODE_RUN: begin
        rate  = w.increment;
        state = (w.increment == 0) ? dsp_pkg::RS_STOPPED : dsp_pkg::RS_CONTINUOUS;
      end
      dsp_pkg::MODE_STOP:    halt();
      dsp_pkg::MODE_MOVE_TO: aim(w.value, w.increment);
      dsp_pkg::MODE_MOVE_BY: aim(position + w.value, w.increment);
      dsp_pkg::MODE_SET_POS: begin
        position = w.value;
        target   = w.value;
      end
    endcase
    r.step_pulse    = pulse;
    r.step_positive = dir_pos;
    r.position_now  = position;
    r.move_done     = (state == dsp_pkg::RS_STOPPED);
    r.axis_enabled  = enabled;
    return r;
  endfunction

  function void note_input(dsp_pkg::in_item_t w);
    pending.push_back(advance(w));
  endfunction

  task report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_result(dsp_pkg::out_item_t got);
    dsp_pkg::out_item_t exp;
    if (pending.size() == 0) begin
      report($sformatf("status word with nothing pending, position %h", got.position_now));
      return;
    end
    exp = pending.pop_front();
    checked++;
    if (got.step_pulse !== exp.step_pulse)
      report($sformatf("word %0d step_pulse %b, want %b", checked, got.step_pulse,
                       exp.step_pulse));
    if (got.step_positive !== exp.step_positive)
      report($sformatf("word %0d step_positive %b, want %b", checked, got.step_positive,
                       exp.step_positive));
    if (got.position_now !== exp.position_now)
      report($sformatf("word %0d position_now %h, want %h", checked, got.position_now,
                       exp.position_now));
    if (got.move_done !== exp.move_done)
      report($sformatf("word %0d move_done %b, want %b", checked, got.move_done,
                       exp.move_done));
    if (got.axis_enabled !== exp.axis_enabled)
      report($sformatf("word %0d axis_enabled %b, want %b", checked, got.axis_enabled,
                       exp.axis_enabled));
  endtask
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int LONG_HOLD   = 64;
  localparam int RANDOM_END  = 540;

  logic clk;
  logic rst_n;

  dsp_in_if  in_ch();
  dsp_out_if out_ch();

  dds_step_pulse_generator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  step_scoreboard sb;
  int  words_sent;
  int  stall_left;
  int  quiet;
  bit  idle_on;
  bit  hold_req;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic send_word(input dsp_pkg::mode_t m, input logic [31:0] v,
                           input logic [31:0] inc);
    dsp_pkg::in_item_t w;
    idle_on = !(words_sent >= 150 && words_sent < 220) && words_sent < 470;
    if (words_sent == 320) hold_req = 1'b1;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.value     <= v;
    in_ch.increment <= inc;
    do @(posedge clk); while (!in_ch.ready);
    w.mode      = m;
    w.value     = v;
    w.increment = inc;
    sb.note_input(w);
    words_sent++;
  endtask

  task automatic tick_run(input int n);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0)
        send_word(dsp_pkg::mode_t'($urandom_range(1, 7)), $urandom, $urandom);
      else
        send_word(dsp_pkg::MODE_TICK, $urandom, $urandom);
    end
  endtask

  // well-formed move: optional repositioning, enable, move, then ticks
  task automatic move_sequence();
    int          delta;
    logic [31:0] inc;
    logic [31:0] spot;
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0: spot = 32'h7FFF_FFF8 + $urandom_range(0, 15);
        1: spot = $urandom_range(0, 15) - 32'd8;
        default: spot = $urandom;
      endcase
      send_word(dsp_pkg::MODE_SET_POS, spot, $urandom);
    end
    if (!sb.enabled || $urandom_range(0, 4) == 0)
      send_word(dsp_pkg::MODE_ENABLE, $urandom | 32'd1, $urandom);
    case ($urandom_range(0, 7))
      0, 1, 2: inc = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
      3, 4:    inc = $urandom_range(32'h7FFF_FFFF, 32'h2000_0000);
      5:       inc = 32'd0;
      default: inc = $urandom;
    endcase
    delta = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
    if ($urandom_range(0, 1)) delta = -delta;
    if ($urandom_range(0, 1))
      send_word(dsp_pkg::MODE_MOVE_BY, delta, inc);
    else
      send_word(dsp_pkg::MODE_MOVE_TO, sb.position + delta, inc);
    tick_run($urandom_range(4, 40));
  endtask

  // out_ch ready: random short stalls, plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      out_ch.ready <= 1'b0;
      stall_left   <= LONG_HOLD - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 16);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    dsp_pkg::out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.step_pulse    = out_ch.step_pulse;
      got.step_positive = out_ch.step_positive;
      got.position_now  = out_ch.position_now;
      got.move_done     = out_ch.move_done;
      got.axis_enabled  = out_ch.axis_enabled;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("no word moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL dds_step_pulse_generator");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    sb              = new();
    words_sent      = 0;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = dsp_pkg::MODE_TICK;
    in_ch.value     = '0;
    in_ch.increment = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_word(dsp_pkg::MODE_TICK, 0, 0);
    send_word(dsp_pkg::MODE_RUN, 32'h7FFF_FFFF, 32'hFFFF_FFFF);   // stored while disabled
    send_word(dsp_pkg::MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(dsp_pkg::MODE_ENABLE, 32'h8000_0001, 0);
    repeat (3) send_word(dsp_pkg::MODE_TICK, 0, 0);
    send_word(dsp_pkg::MODE_DIR, 32'hFFFF_FFFE, 0);
    repeat (2) send_word(dsp_pkg::MODE_TICK, 0, 0);
    send_word(dsp_pkg::MODE_RUN, 32'h8000_0000, 0);               // zero rate stops
    send_word(dsp_pkg::MODE_TICK, 0, 0);
    send_word(dsp_pkg::MODE_SET_POS, 32'h7FFF_FFFF, 0);
    send_word(dsp_pkg::MODE_DIR, 1, 0);
    send_word(dsp_pkg::MODE_RUN, 0, 32'h8000_0000);
    repeat (2) send_word(dsp_pkg::MODE_TICK, 0, 0);               // wraps past the signed max
    send_word(dsp_pkg::MODE_MOVE_TO, sb.position, 1);             // already there
    send_word(dsp_pkg::MODE_MOVE_BY, 0, 32'h1234_5678);
    send_word(dsp_pkg::MODE_MOVE_TO, 32'h8000_0003, 0);
    send_word(dsp_pkg::MODE_MOVE_BY, -2, 32'hFFFF_FFFF);          // target wraps, goes positive
    send_word(dsp_pkg::MODE_TICK, 0, 0);
    send_word(dsp_pkg::MODE_ENABLE, 32'hFFFF_FFFE, 0);            // disable keeps the rate
    send_word(dsp_pkg::MODE_TICK, 0, 0);
    send_word(dsp_pkg::MODE_ENABLE, 1, 0);
    send_word(dsp_pkg::MODE_TICK, 0, 0);
    send_word(dsp_pkg::MODE_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    while (words_sent < RANDOM_END) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: move_sequence();
        5, 6: begin
          send_word(dsp_pkg::MODE_DIR, $urandom, $urandom);
          send_word(dsp_pkg::MODE_RUN, $urandom, ($urandom_range(0, 3) == 0) ? $urandom
                              : $urandom_range(32'hFFFF_FFFF, 32'h4000_0000));
          tick_run($urandom_range(3, 25));
        end
        default: begin
          repeat ($urandom_range(1, 4))
            send_word(dsp_pkg::mode_t'($urandom_range(0, 7)), $urandom, $urandom);
        end
      endcase
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d words sent, %0d status words checked", words_sent, sb.checked);
    $display("%0d step pulses, %0d moves reached their target", sb.steps, sb.arrivals);
    if (sb.errors == 0) begin
      $display("PASS dds_step_pulse_generator");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL dds_step_pulse_generator");
    end
    $finish;
  end
endmodule

### sim.f
rtl/core/dsp_pkg.sv
rtl/core/dsp_if.sv
rtl/core/dsp_in_reg.sv
rtl/core/dsp_axis.sv
rtl/core/dds_step_pulse_generator.sv
bench/tb.sv
